// ===== hdl/tlptm_pkg.sv =====
// shared types, constants and enums for the two-level page table manager
package tlptm_pkg;

  // default size of the page table pool
  localparam int unsigned NumTablesDef = 16;

  // address split and entry layout
  localparam int unsigned IdxW       = 10;
  localparam int unsigned DirEntries = 1 << IdxW;
  localparam int unsigned DirShift   = 22;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitLarge   = 7;

  localparam logic [11:0] EntPresent = 12'h001;
  localparam logic [11:0] EntLarge   = 12'h080;

  // command codes
  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_MAP_SMALL = 2'd1,
    CMD_MAP_LARGE = 2'd2,
    CMD_UNMAP     = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_UNMAPPED = 3'd1,
    STAT_NOSPACE  = 3'd2,
    STAT_MISALIGN = 3'd3,
    STAT_CONFLICT = 3'd4
  } status_e;

  // how the result address is formed
  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_PASS  = 2'd1,
    RES_LARGE = 2'd2,
    RES_SMALL = 2'd3
  } res_sel_e;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_DIR   = 3'd2,
    S_PDE   = 3'd3,
    S_PTE   = 3'd4,
    S_FIN   = 3'd5
  } state_e;

  // input item
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic [11:0] page_flags;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] translated_address;
    logic        mapped;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic     clear;
    logic     capture;
    logic     dir_rd;
    logic     pool_rd;
    logic     dir_wr_tab;
    logic     dir_wr_large;
    logic     pool_wr_map;
    logic     pool_wr_zero;
    logic     res_we;
    res_sel_e res_sel;
    status_e  res_status;
    logic     out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
    cmd_e cmd;
    logic paging;
    logic pde_large;
    logic tab_ok;
    logic pool_full;
    logic misaligned;
    logic pte_valid;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hdl/tlptm_ctrl.sv =====
// sequencing state machine for the page table manager
module tlptm_ctrl import tlptm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DIR;
        end
      end
      S_DIR: begin
        cmd_o.dir_rd = 1'b1;
        state_d      = S_PDE;
      end
      S_PDE: begin
        cmd_o.res_we = 1'b1;
        state_d      = S_FIN;
        unique case (stat_i.cmd)
          CMD_TRANSLATE: begin
            priority if (!stat_i.paging) begin
              cmd_o.res_sel = RES_PASS;
            end else if (stat_i.pde_large) begin
              cmd_o.res_sel = RES_LARGE;
            end else if (stat_i.tab_ok) begin
              cmd_o.res_we  = 1'b0;
              cmd_o.pool_rd = 1'b1;
              state_d       = S_PTE;
            end else begin
              cmd_o.res_status = STAT_UNMAPPED;
            end
          end
          CMD_MAP_SMALL: begin
            priority if (stat_i.pde_large) begin
              cmd_o.res_status = STAT_CONFLICT;
            end else if (stat_i.tab_ok) begin
              cmd_o.pool_wr_map = 1'b1;
            end else if (stat_i.pool_full) begin
              cmd_o.res_status = STAT_NOSPACE;
            end else begin
              cmd_o.dir_wr_tab  = 1'b1;
              cmd_o.pool_wr_map = 1'b1;
            end
          end
          CMD_MAP_LARGE: begin
            if (stat_i.misaligned) begin
              cmd_o.res_status = STAT_MISALIGN;
            end else begin
              cmd_o.dir_wr_large = 1'b1;
            end
          end
          CMD_UNMAP: begin
            priority if (stat_i.pde_large) begin
              cmd_o.res_status = STAT_CONFLICT;
            end else if (stat_i.tab_ok) begin
              cmd_o.pool_wr_zero = 1'b1;
            end else begin
              cmd_o.res_status = STAT_UNMAPPED;
            end
          end
          default: begin
            cmd_o.res_status = STAT_UNMAPPED;
          end
        endcase
      end
      S_PTE: begin
        cmd_o.res_we = 1'b1;
        state_d      = S_FIN;
        if (stat_i.pte_valid) begin
          cmd_o.res_sel = RES_SMALL;
        end else begin
          cmd_o.res_status = STAT_UNMAPPED;
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== hdl/tlptm_dp.sv =====
// datapath: directory and table pool memories, request, result and output registers
module tlptm_dp import tlptm_pkg::*; #(
  parameter int unsigned NUM_TABLES = NumTablesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_data_i,
  output out_item_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o
);

  localparam int unsigned TabW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned CntW      = $clog2(NUM_TABLES + 1);
  localparam int unsigned PoolAw    = TabW + IdxW;
  localparam int unsigned PoolDepth = NUM_TABLES * DirEntries;

  logic [31:0] dir_mem  [DirEntries];
  logic [31:0] pool_mem [PoolDepth];

  in_item_t         req_q;
  logic             paging_q;
  logic [CntW-1:0]  used_q;
  logic [PoolAw-1:0] clr_q;
  logic [31:0]      pde_q, pte_q;
  out_item_t        res_q, res_d, out_q;
  logic             out_valid_q;

  logic [IdxW-1:0]   di, ti;
  logic [TabW-1:0]   pde_tab, wr_tab;
  logic              idx_ok, pde_large, tab_ok, pool_full;
  logic              dir_we, pool_we;
  logic [IdxW-1:0]   dir_waddr;
  logic [31:0]       dir_wdata, pool_wdata;
  logic [PoolAw-1:0] pool_waddr, pool_raddr;

  // address fields and directory entry decode
  assign di        = req_q.virtual_address[DirShift +: IdxW];
  assign ti        = req_q.virtual_address[PageShift +: IdxW];
  assign pde_tab   = pde_q[PageShift +: TabW];
  assign idx_ok    = pde_q[31:PageShift] < 20'(NUM_TABLES);
  assign pde_large = pde_q[BitPresent] & pde_q[BitLarge];
  assign tab_ok    = pde_q[BitPresent] & ~pde_q[BitLarge] & idx_ok;
  assign pool_full = used_q >= CntW'(NUM_TABLES);

  // directory write port
  assign dir_we    = cmd_i.clear | cmd_i.dir_wr_tab | cmd_i.dir_wr_large;
  assign dir_waddr = cmd_i.clear ? clr_q[IdxW-1:0] : di;
  always_comb begin
    if (cmd_i.clear) begin
      dir_wdata = '0;
    end else if (cmd_i.dir_wr_large) begin
      dir_wdata = {req_q.physical_address[31:DirShift], 10'b0,
                   req_q.page_flags | EntLarge | EntPresent};
    end else begin
      dir_wdata = {20'(used_q), (req_q.page_flags & ~EntLarge) | EntPresent};
    end
  end

  // pool write port, a new table takes the next free index
  assign pool_we    = cmd_i.clear | cmd_i.pool_wr_map | cmd_i.pool_wr_zero;
  assign wr_tab     = cmd_i.dir_wr_tab ? used_q[TabW-1:0] : pde_tab;
  assign pool_waddr = cmd_i.clear ? clr_q : {wr_tab, ti};
  assign pool_wdata = cmd_i.pool_wr_map ?
                      {req_q.physical_address[31:PageShift], req_q.page_flags | EntPresent} :
                      32'h0;
  assign pool_raddr = {pde_tab, ti};

  // directory memory
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (cmd_i.dir_rd) begin
      pde_q <= dir_mem[di];
    end
  end

  // table pool memory
  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    if (cmd_i.pool_rd) begin
      pte_q <= pool_mem[pool_raddr];
    end
  end

  // control registers: paging flag, table count, clearing sweep, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q    <= 1'b0;
      used_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        paging_q <= cfg_data_i;
      end
      if (cmd_i.dir_wr_tab) begin
        used_q <= used_q + CntW'(1);
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + PoolAw'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result forming
  always_comb begin
    res_d.status = cmd_i.res_status;
    unique case (cmd_i.res_sel)
      RES_PASS: begin
        res_d.translated_address = req_q.virtual_address;
        res_d.mapped             = 1'b1;
      end
      RES_LARGE: begin
        res_d.translated_address = {pde_q[31:DirShift], req_q.virtual_address[DirShift-1:0]};
        res_d.mapped             = 1'b1;
      end
      RES_SMALL: begin
        res_d.translated_address = {pte_q[31:PageShift],
                                    req_q.virtual_address[PageShift-1:0]};
        res_d.mapped             = 1'b1;
      end
      default: begin
        res_d.translated_address = '0;
        res_d.mapped             = 1'b0;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    if (cmd_i.res_we) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  // status back to the controller
  assign stat_o.clear_done  = clr_q == PoolAw'(PoolDepth - 1);
  assign stat_o.cmd         = cmd_e'(req_q.command);
  assign stat_o.paging      = paging_q;
  assign stat_o.pde_large   = pde_large;
  assign stat_o.tab_ok      = tab_ok;
  assign stat_o.pool_full   = pool_full;
  assign stat_o.misaligned  = (req_q.virtual_address[DirShift-1:0] != '0) ||
                              (req_q.physical_address[DirShift-1:0] != '0);
  assign stat_o.pte_valid   = pte_q[BitPresent];
  assign stat_o.out_busy    = out_valid_q & out_stall_i;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(NUM_TABLES))
    else $error("table count beyond pool size");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dir_wr_tab |-> !pool_full && cmd_i.pool_wr_map)
    else $error("table allocated without room or without entry write");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while held");

  a_pool_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pool_rd |-> !pool_we)
    else $error("pool read and write in the same cycle");
`endif

endmodule

// ===== hdl/two_level_page_table_manager.sv =====
// top level of the two-level page table manager
//
//  channel  direction  handshake            payload
//  in       input      in_valid_i/in_stall_o   in_item_t: command, addresses, flags
//  out      output     out_valid_o/out_stall_i out_item_t: status, address, mapped
//  cfg      input      cfg_valid_i/cfg_ready_o paging_enabled bit
//
//  after reset the directory and the table pool are swept to zero, one entry a cycle,
//  until every pool entry is cleared; no item is taken meanwhile, configuration writes are
//  taken in any cycle
//  an item is captured, its directory entry is read and decided on, a translate that walks
//  into a table also reads that table, and the result is then loaded into the output
//  register; the directory and table reads are registered, as both memories read synchronously
//  a stalled result holds in the output register; one more item is taken and
//  finished behind it and waits until the output register frees
module two_level_page_table_manager import tlptm_pkg::*; #(
  parameter int unsigned NUM_TABLES = NumTablesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  tlptm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  tlptm_dp #(
    .NUM_TABLES (NUM_TABLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== tb/two_level_page_table_manager_tb.sv =====
// testbench for the two-level page table manager: directed table, random commands, scoreboard
`timescale 1ns / 1ps

module two_level_page_table_manager_tb import tlptm_pkg::*; ();

  localparam int unsigned NumTables = NumTablesDef;
  localparam logic [31:0] FrameMask = 32'hFFFF_F000;
  localparam logic [31:0] LargeMask = 32'hFFC0_0000;
  localparam int unsigned IdleLimit = 100000;
  localparam int unsigned LongHold  = 400;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  two_level_page_table_manager #(
    .NUM_TABLES(NumTables)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // shadow copy of the translation state
  logic [31:0] dir_model  [DirEntries];
  logic [31:0] pool_model [NumTables * DirEntries];
  int unsigned tables_taken;
  logic        paging_model;

  out_item_t   pending_results [$];
  logic [31:0] recent_pages [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int          burst_left;
  bit          long_hold_done;

  // directed stimulus rows
  typedef struct {
    logic      paging;
    in_item_t  item;
    bit        typed;
    out_item_t want;
    int        reps;
  } drow_t;

  drow_t dir_rows [$];

  // directory entry pointing at a usable table
  function automatic bit find_table(input logic [31:0] pde, output int unsigned tab);
    tab = 32'(pde[31:12]);
    return pde[BitPresent] && !pde[BitLarge] && (tab < NumTables);
  endfunction

  // walk and update the shadow tables for one command
  function automatic out_item_t walk_tables(input in_item_t it);
    logic [9:0]  di;
    logic [9:0]  ti;
    logic [31:0] pde;
    logic [31:0] pte;
    logic [31:0] va;
    logic [31:0] pa;
    logic [11:0] fl;
    int unsigned tab;
    bit          is_large;
    bit          ok;
    out_item_t   r;
    va = it.virtual_address;
    pa = it.physical_address;
    fl = it.page_flags;
    di = va[31:22];
    ti = va[21:12];
    pde = dir_model[di];
    is_large = pde[BitPresent] && pde[BitLarge];
    r = '0;
    r.status = STAT_OK;
    case (cmd_e'(it.command))
      CMD_TRANSLATE: begin
        if (!paging_model) begin
          r.translated_address = va;
          r.mapped = 1'b1;
        end else if (is_large) begin
          r.translated_address = (pde & LargeMask) | (va & ~LargeMask);
          r.mapped = 1'b1;
        end else if (find_table(pde, tab)) begin
          pte = pool_model[tab * DirEntries + ti];
          if (pte[BitPresent]) begin
            r.translated_address = (pte & FrameMask) | {20'h0, va[11:0]};
            r.mapped = 1'b1;
          end else begin
            r.status = STAT_UNMAPPED;
          end
        end else begin
          r.status = STAT_UNMAPPED;
        end
      end
      CMD_MAP_SMALL: begin
        if (is_large) begin
          r.status = STAT_CONFLICT;
        end else begin
          ok = find_table(pde, tab);
          if (!ok) begin
            if (tables_taken >= NumTables) begin
              r.status = STAT_NOSPACE;
            end else begin
              tab = tables_taken;
              tables_taken++;
              // size bit never survives into a table pointer
              dir_model[di] = (32'(tab) << PageShift)
                              | {20'h0, (fl & ~EntLarge) | EntPresent};
              ok = 1'b1;
            end
          end
          if (ok) pool_model[tab * DirEntries + ti] = (pa & FrameMask) | {20'h0, fl | EntPresent};
        end
      end
      CMD_MAP_LARGE: begin
        if (va[21:0] != '0 || pa[21:0] != '0) begin
          r.status = STAT_MISALIGN;
        end else begin
          dir_model[di] = (pa & LargeMask) | {20'h0, fl | EntPresent | EntLarge};
        end
      end
      default: begin
        if (is_large) begin
          r.status = STAT_CONFLICT;
        end else if (find_table(pde, tab)) begin
          pool_model[tab * DirEntries + ti] = '0;
        end else begin
          r.status = STAT_UNMAPPED;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(logic pg, cmd_e c, logic [31:0] va, logic [31:0] pa,
                                  logic [11:0] fl, bit typed, status_e st,
                                  logic [31:0] addr, logic hit, int reps = 1);
    drow_t row;
    row.paging = pg;
    row.item.command = c;
    row.item.virtual_address = va;
    row.item.physical_address = pa;
    row.item.page_flags = fl;
    row.typed = typed;
    row.want.status = st;
    row.want.translated_address = addr;
    row.want.mapped = hit;
    row.reps = reps;
    dir_rows.push_back(row);
  endfunction

  // random command, mostly aimed at directory slots that hold tables
  function automatic in_item_t rand_item();
    in_item_t    it;
    int          sel;
    logic [9:0]  di;
    logic [9:0]  ti;
    sel = $urandom_range(0, 99);
    it.command = sel < 40 ? CMD_TRANSLATE : sel < 65 ? CMD_MAP_SMALL :
                 sel < 80 ? CMD_MAP_LARGE : CMD_UNMAP;
    it.physical_address = $urandom;
    it.page_flags = 12'($urandom);
    case ($urandom_range(0, 3))
      0, 1:    di = 10'($urandom_range(32, 47));
      2:       di = 10'($urandom_range(0, 7));
      default: di = 10'($urandom);
    endcase
    ti = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
    it.virtual_address = {di, ti, 12'($urandom)};
    if (cmd_e'(it.command) inside {CMD_TRANSLATE, CMD_UNMAP} &&
        recent_pages.size() > 0 && $urandom_range(0, 9) < 7) begin
      it.virtual_address = {recent_pages[$urandom_range(0, recent_pages.size() - 1)][31:12],
                            12'($urandom)};
    end
    if (cmd_e'(it.command) == CMD_MAP_LARGE) begin
      if ($urandom_range(0, 1) == 0) it.virtual_address[31:22] = 10'($urandom_range(48, 63));
      if ($urandom_range(0, 9) < 7) begin
        it.virtual_address[21:0] = '0;
        it.physical_address[21:0] = '0;
      end
    end
    if (cmd_e'(it.command) inside {CMD_MAP_SMALL, CMD_MAP_LARGE}) begin
      recent_pages.push_back(it.virtual_address);
      if (recent_pages.size() > 24) void'(recent_pages.pop_front());
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // one command transfer, expectation recorded at acceptance
  task automatic send_command(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = walk_tables(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // bursts of back-to-back commands with gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // hold input until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_paging(input logic value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    paging_model = value;
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data_o));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data_o.status, want.status));
        if (out_data_o.translated_address !== want.translated_address)
          report_mismatch($sformatf("address %h, want %h",
                                    out_data_o.translated_address, want.translated_address));
        if (out_data_o.mapped !== want.mapped)
          report_mismatch($sformatf("mapped %b, want %b", out_data_o.mapped, want.mapped));
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin
    int mode;
    int left;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(16, 96);
      repeat (left) begin
        @(posedge clk_i);
        if (!long_hold_done && results_seen >= 150) begin
          long_hold_done = 1'b1;
          out_stall_i <= 1'b1;
          repeat (LongHold) @(posedge clk_i);
        end else begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 3) == 0);
            2:       out_stall_i <= ($urandom_range(0, 1) == 0);
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[two_level_page_table_manager] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    in_item_t  it;
    out_item_t none;
    foreach (dir_model[i]) dir_model[i] = '0;
    foreach (pool_model[i]) pool_model[i] = '0;
    tables_taken = 0;
    paging_model = 1'b0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    long_hold_done = 1'b0;
    none = '0;

    // paging off: pass-through, misalignment and conflicts
    add_row(1'b0, CMD_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000, 1, STAT_OK, 32'h0000_0000, 1);
    add_row(1'b0, CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000, 1, STAT_OK, 32'hFFFF_FFFF, 1);
    add_row(1'b0, CMD_UNMAP, 32'h0000_0000, 32'h0, 12'h000, 1, STAT_UNMAPPED, 32'h0, 0);
    add_row(1'b0, CMD_MAP_LARGE, 32'h0040_0001, 32'h0, 12'h000, 1, STAT_MISALIGN, 32'h0, 0);
    add_row(1'b0, CMD_MAP_LARGE, 32'h0080_0000, 32'h0020_0000, 12'h000, 1, STAT_MISALIGN,
            32'h0, 0);
    add_row(1'b0, CMD_MAP_LARGE, 32'hFFC0_0000, 32'hFFC0_0000, 12'hFFF, 1, STAT_OK, 32'h0, 0);
    add_row(1'b0, CMD_MAP_SMALL, 32'hFFC0_1000, 32'h1234_5000, 12'h000, 1, STAT_CONFLICT,
            32'h0, 0);
    add_row(1'b0, CMD_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000, 1, STAT_CONFLICT, 32'h0, 0);
    // paging on: large hit, table walk, unmap, large over table, pool exhaustion
    add_row(1'b1, CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000, 1, STAT_UNMAPPED, 32'h0, 0);
    add_row(1'b1, CMD_MAP_SMALL, 32'h0000_1000, 32'hFFFF_FFFF, 12'h080, 1, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_TRANSLATE, 32'h0000_1ABC, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_TRANSLATE, 32'h0000_2000, 32'h0, 12'h000, 1, STAT_UNMAPPED, 32'h0, 0);
    add_row(1'b1, CMD_MAP_SMALL, 32'h0000_2000, 32'h0000_0000, 12'h000, 1, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_TRANSLATE, 32'h0000_2FFF, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_UNMAP, 32'h0000_1000, 32'h0, 12'h000, 1, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_TRANSLATE, 32'h0000_1000, 32'h0, 12'h000, 1, STAT_UNMAPPED, 32'h0, 0);
    add_row(1'b1, CMD_MAP_LARGE, 32'h0000_0000, 32'h0040_0000, 12'h000, 1, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_TRANSLATE, 32'h0012_3456, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_MAP_SMALL, 32'h0800_0000, 32'hA5A5_A000, 12'h5A5, 0, STAT_OK, 32'h0,
            0, 15);
    add_row(1'b1, CMD_MAP_SMALL, 32'h0BC0_0000, 32'h0, 12'h000, 1, STAT_NOSPACE, 32'h0, 0);
    add_row(1'b1, CMD_MAP_SMALL, 32'h0800_3000, 32'h5A5A_5000, 12'hA5A, 1, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_TRANSLATE, 32'h0800_3ABC, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 0);
    add_row(1'b1, CMD_UNMAP, 32'h0BC0_0000, 32'h0, 12'h000, 1, STAT_UNMAPPED, 32'h0, 0);

    // reset, then the clearing sweep runs inside the block
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_paging(1'b0);

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].paging !== paging_model) begin
        settle();
        write_paging(dir_rows[i].paging);
      end
      for (int r = 0; r < dir_rows[i].reps; r++) begin
        it = dir_rows[i].item;
        it.virtual_address = it.virtual_address + (32'(r) << DirShift);
        send_command(it, dir_rows[i].typed, dir_rows[i].want);
        pace();
      end
    end

    // random part, paging off in the second phase and on in the others
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_paging(ph != 1);
      for (int n = 0; n < 200; n++) begin
        send_command(rand_item(), 1'b0, none);
        pace();
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[two_level_page_table_manager] OK");
    end else begin
      $display("[two_level_page_table_manager] ERROR");
    end
    $finish;
  end

endmodule
